// ===== src/rjfr_pkg.sv =====
// Types, constants and helpers shared by the RTP/JPEG fragment reassembler.
`default_nettype none
package rjfr_pkg;

  localparam int unsigned NumSlots = 4;
  // Only four slots carry a bit in the free mask.
  localparam int unsigned NumPick  = (NumSlots < 4) ? NumSlots : 4;

  localparam int unsigned LenW     = 16;
  localparam int unsigned OffW     = 24;
  localparam int unsigned MaskW    = 4;
  localparam int unsigned SlotW    = 2;
  localparam int unsigned AddrW    = 25;
  localparam int unsigned HdrW     = 10;
  localparam int unsigned SeqW     = 32;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 25;

  localparam logic [LenW-1:0]     MinPacketBytes = LenW'(20);
  localparam logic [AddrW-1:0]    EoiBytes       = AddrW'(2);
  localparam logic [AddrW-1:0]    BufSizeReset   = AddrW'(262144);
  localparam logic [HdrW-1:0]     HdrLenReset    = HdrW'(605);
  localparam logic [SeqW-1:0]     SeqReset       = SeqW'(1);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BUFFER_SIZE   = 1'b0,
    CFG_HEADER_LENGTH = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_SHORT    = 3'd0,
    ST_DISCARD  = 3'd1,
    ST_NOSLOT   = 3'd2,
    ST_GAP      = 3'd3,
    ST_OVERFLOW = 3'd4,
    ST_WRITTEN  = 3'd5
  } status_e;

  typedef struct packed {
    logic [LenW-1:0]  packet_length;
    logic             marker;
    logic [OffW-1:0]  fragment_offset;
    logic [MaskW-1:0] free_slots;
  } req_t;

  typedef struct packed {
    logic valid;
    req_t req;
  } stage_t;

  typedef struct packed {
    logic             found;
    logic [SlotW-1:0] idx;
  } slot_pick_t;

  // Lowest set bit of the free mask among the usable slots.
  function automatic slot_pick_t pick_free(input logic [MaskW-1:0] mask);
    slot_pick_t r;
    r.found = 1'b0;
    r.idx   = '0;
    for (int k = NumPick - 1; k >= 0; k--) begin
      if (mask[k]) begin
        r.found = 1'b1;
        r.idx   = SlotW'(k);
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== src/rjfr_req_if.sv =====
// Request channel carrying one packet header.
`default_nettype none
interface rjfr_req_if;
  logic                       valid;
  logic                       ready;
  logic [rjfr_pkg::LenW-1:0]  packet_length;
  logic                       marker;
  logic [rjfr_pkg::OffW-1:0]  fragment_offset;
  logic [rjfr_pkg::MaskW-1:0] free_slots;

  modport source (output valid, packet_length, marker, fragment_offset, free_slots,
                  input ready);
  modport sink   (input valid, packet_length, marker, fragment_offset, free_slots,
                  output ready);
endinterface
`default_nettype wire

// ===== src/rjfr_res_if.sv =====
// Result channel carrying one tracker verdict per packet.
`default_nettype none
interface rjfr_res_if;
  logic                       valid;
  logic                       ready;
  logic [2:0]                 status;
  logic [rjfr_pkg::SlotW-1:0] slot;
  logic                       start_frame;
  logic [rjfr_pkg::AddrW-1:0] write_address;
  logic [rjfr_pkg::LenW-1:0]  write_length;
  logic                       frame_done;
  logic [rjfr_pkg::AddrW-1:0] frame_size;
  logic [rjfr_pkg::SeqW-1:0]  frame_sequence;

  modport source (output valid, status, slot, start_frame, write_address, write_length,
                         frame_done, frame_size, frame_sequence,
                  input ready);
  modport sink   (input valid, status, slot, start_frame, write_address, write_length,
                        frame_done, frame_size, frame_sequence,
                  output ready);
endinterface
`default_nettype wire

// ===== src/rjfr_in_reg.sv =====
// Input register stage for packet header requests.
`default_nettype none
module rjfr_in_reg (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  rjfr_req_if.sink             req_i,
  input  wire logic            advance_i,
  output rjfr_pkg::stage_t     stage_o
);

  logic            valid_q, valid_d;
  rjfr_pkg::req_t  req_q, req_d;
  logic            take;

  // Stage frees up when empty or when its item moves on this cycle.
  assign req_i.ready = !valid_q || advance_i;
  assign take        = req_i.valid && req_i.ready;

  always_comb begin
    valid_d = valid_q;
    req_d   = req_q;
    if (req_i.ready) begin
      valid_d = req_i.valid;
    end
    if (take) begin
      req_d.packet_length   = req_i.packet_length;
      req_d.marker          = req_i.marker;
      req_d.fragment_offset = req_i.fragment_offset;
      req_d.free_slots      = req_i.free_slots;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
  end

  assign stage_o.valid = valid_q;
  assign stage_o.req   = req_q;

endmodule
`default_nettype wire

// ===== src/rjfr_tracker.sv =====
// Frame tracker state, per-packet decision logic and result register.
`default_nettype none
module rjfr_tracker (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [rjfr_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [rjfr_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire rjfr_pkg::stage_t               stage_i,
  output logic                                advance_o,
  rjfr_res_if.source                          res_o
);

  // Configuration
  logic [rjfr_pkg::AddrW-1:0] buf_size_q;
  logic [rjfr_pkg::HdrW-1:0]  hdr_len_q;

  // Frame state
  logic                        held_q, held_d;
  logic [rjfr_pkg::SlotW-1:0]  slot_q, slot_d;
  logic [rjfr_pkg::AddrW-1:0]  exp_q, exp_d;
  logic                        corrupt_q, corrupt_d;
  logic [rjfr_pkg::SeqW-1:0]   seq_q, seq_d;

  // Result register
  logic                        rvalid_q, rvalid_d;
  rjfr_pkg::status_e           status_q, status_d;
  logic [rjfr_pkg::SlotW-1:0]  rslot_q, rslot_d;
  logic                        start_q, start_d;
  logic [rjfr_pkg::AddrW-1:0]  waddr_q, waddr_d;
  logic [rjfr_pkg::LenW-1:0]   wlen_q, wlen_d;
  logic                        done_q, done_d;
  logic [rjfr_pkg::AddrW-1:0]  fsize_q, fsize_d;
  logic [rjfr_pkg::SeqW-1:0]   fseq_q, fseq_d;

  rjfr_pkg::req_t              req;
  rjfr_pkg::slot_pick_t        pick;
  logic                        fire;
  logic [rjfr_pkg::LenW-1:0]   plen;
  logic [rjfr_pkg::AddrW-1:0]  off_ext;
  logic [rjfr_pkg::AddrW-1:0]  wo;
  logic [rjfr_pkg::AddrW:0]    fit_sum;
  // Claim-stage values, before the contiguity and fit checks
  logic                        held_c;
  logic [rjfr_pkg::SlotW-1:0]  slot_c;
  logic [rjfr_pkg::AddrW-1:0]  exp_c;
  logic                        corrupt_c;

  assign req       = stage_i.req;
  assign advance_o = !rvalid_q || res_o.ready;
  assign fire      = stage_i.valid && advance_o;
  assign pick      = rjfr_pkg::pick_free(req.free_slots);
  assign plen      = req.packet_length - rjfr_pkg::MinPacketBytes;
  assign off_ext   = rjfr_pkg::AddrW'(req.fragment_offset);
  assign wo        = rjfr_pkg::AddrW'(hdr_len_q) + off_ext;
  assign fit_sum   = (rjfr_pkg::AddrW+1)'(wo) + (rjfr_pkg::AddrW+1)'(plen)
                   + (rjfr_pkg::AddrW+1)'(rjfr_pkg::EoiBytes);

  always_comb begin
    held_d    = held_q;
    slot_d    = slot_q;
    exp_d     = exp_q;
    corrupt_d = corrupt_q;
    seq_d     = seq_q;

    held_c    = held_q;
    slot_c    = slot_q;
    exp_c     = exp_q;
    corrupt_c = corrupt_q;

    status_d  = rjfr_pkg::ST_DISCARD;
    rslot_d   = held_q ? slot_q : '0;
    start_d   = 1'b0;
    waddr_d   = '0;
    wlen_d    = '0;
    done_d    = 1'b0;
    fsize_d   = '0;
    fseq_d    = '0;

    if (req.packet_length < rjfr_pkg::MinPacketBytes) begin
      // short packet: report only, state untouched
      status_d = rjfr_pkg::ST_SHORT;
    end else begin
      if (req.fragment_offset == '0) begin
        held_c    = pick.found;
        slot_c    = pick.idx;
        corrupt_c = !pick.found;
        exp_c     = '0;
        if (pick.found) begin
          start_d = 1'b1;
        end else begin
          status_d = rjfr_pkg::ST_NOSLOT;
        end
      end

      held_d    = held_c;
      slot_d    = slot_c;
      exp_d     = exp_c;
      corrupt_d = corrupt_c;

      if (!corrupt_c && held_c) begin
        if (off_ext != exp_c) begin
          corrupt_d = 1'b1;
          status_d  = rjfr_pkg::ST_GAP;
        end else if (fit_sum <= (rjfr_pkg::AddrW+1)'(buf_size_q)) begin
          status_d = rjfr_pkg::ST_WRITTEN;
          waddr_d  = wo;
          wlen_d   = plen;
          exp_d    = off_ext + rjfr_pkg::AddrW'(plen);
        end else begin
          corrupt_d = 1'b1;
          status_d  = rjfr_pkg::ST_OVERFLOW;
        end
      end

      rslot_d = held_c ? slot_c : '0;

      if (req.marker) begin
        if (!corrupt_d && held_c) begin
          done_d  = 1'b1;
          fsize_d = rjfr_pkg::AddrW'(hdr_len_q) + exp_d + rjfr_pkg::EoiBytes;
          fseq_d  = seq_q;
          seq_d   = seq_q + rjfr_pkg::SeqW'(1);
        end
        held_d    = 1'b0;
        exp_d     = '0;
        corrupt_d = 1'b1;
      end
    end
  end

  always_comb begin
    rvalid_d = rvalid_q;
    if (advance_o) begin
      rvalid_d = stage_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_size_q <= rjfr_pkg::BufSizeReset;
      hdr_len_q  <= rjfr_pkg::HdrLenReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rjfr_pkg::CFG_BUFFER_SIZE:   buf_size_q <= cfg_data_i[rjfr_pkg::AddrW-1:0];
        rjfr_pkg::CFG_HEADER_LENGTH: hdr_len_q  <= cfg_data_i[rjfr_pkg::HdrW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q    <= 1'b0;
      slot_q    <= '0;
      exp_q     <= '0;
      corrupt_q <= 1'b1;
      seq_q     <= rjfr_pkg::SeqReset;
      rvalid_q  <= 1'b0;
    end else begin
      rvalid_q <= rvalid_d;
      if (fire) begin
        held_q    <= held_d;
        slot_q    <= slot_d;
        exp_q     <= exp_d;
        corrupt_q <= corrupt_d;
        seq_q     <= seq_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q <= status_d;
      rslot_q  <= rslot_d;
      start_q  <= start_d;
      waddr_q  <= waddr_d;
      wlen_q   <= wlen_d;
      done_q   <= done_d;
      fsize_q  <= fsize_d;
      fseq_q   <= fseq_d;
    end
  end

  assign res_o.valid          = rvalid_q;
  assign res_o.status         = status_q;
  assign res_o.slot           = rslot_q;
  assign res_o.start_frame    = start_q;
  assign res_o.write_address  = waddr_q;
  assign res_o.write_length   = wlen_q;
  assign res_o.frame_done     = done_q;
  assign res_o.frame_size     = fsize_q;
  assign res_o.frame_sequence = fseq_q;

endmodule
`default_nettype wire

// ===== src/rtp_jpeg_fragment_reassembler_top.sv =====
// Top level of the RTP/JPEG fragment reassembly tracker.
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+---------------------------------------------
//  req_i    | in  | valid/ready   | packet_length, marker, fragment_offset,
//           |     |               | free_slots
//  res_o    | out | valid/ready   | status, slot, start_frame, write_address,
//           |     |               | write_length, frame_done, frame_size,
//           |     |               | frame_sequence
//  cfg_*    | in  | cfg_we_i only | cfg_idx_i (0 buffer_size, 1 header_length),
//           |     |               | cfg_data_i
//
// A request passes an input register, then the tracker logic (slot pick,
// offset compare, the adds and fit compare) into the result register. One
// request per cycle is taken while the result side does not stall; the
// tracker state registers feed straight back into the decision logic.
// Async active-low reset clears the pipeline valids and the frame state (no
// slot held, corrupt set, sequence 1) and loads the register defaults.
// A stalled result holds the pipeline; req_i.ready stays high while either
// stage has room.
`default_nettype none
module rtp_jpeg_fragment_reassembler_top (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  rjfr_req_if.sink                            req_i,
  rjfr_res_if.source                          res_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [rjfr_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [rjfr_pkg::CfgDataW-1:0]  cfg_data_i
);

  rjfr_pkg::stage_t stage;
  logic             advance;

  // request capture
  rjfr_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_i),
    .advance_i (advance),
    .stage_o   (stage)
  );

  // decision logic, frame state, registers and result register
  rjfr_tracker u_tracker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .stage_i    (stage),
    .advance_o  (advance),
    .res_o      (res_o)
  );

endmodule
`default_nettype wire

// ===== test/rtp_jpeg_fragment_reassembler_top_tb.sv =====
// Self-checking testbench for the RTP/JPEG fragment reassembly tracker top level.
module rtp_jpeg_fragment_reassembler_top_tb;

  localparam int unsigned CycleLimit  = 200000;
  // Spare cycles after the pipeline drains, before config writes and at the end.
  localparam int unsigned DrainCycles = 6;
  localparam logic [rjfr_pkg::SlotW:0] NoSlot = (rjfr_pkg::SlotW+1)'(rjfr_pkg::NumSlots);

  // Expected verdict for one packet header.
  typedef struct packed {
    rjfr_pkg::status_e          status;
    logic [rjfr_pkg::SlotW-1:0] slot;
    logic                       start;
    logic [rjfr_pkg::AddrW-1:0] waddr;
    logic [rjfr_pkg::LenW-1:0]  wlen;
    logic                       done;
    logic [rjfr_pkg::AddrW-1:0] fsize;
    logic [rjfr_pkg::SeqW-1:0]  fseq;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [rjfr_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [rjfr_pkg::CfgDataW-1:0] cfg_data_i;

  rjfr_req_if req_if ();
  rjfr_res_if res_if ();

  rtp_jpeg_fragment_reassembler_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .res_o      (res_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Packet headers waiting to be offered, and verdicts waiting for their result.
  rjfr_pkg::req_t header_q[$];
  verdict_t       verdict_q[$];

  // Tracker copy used for prediction.
  logic [rjfr_pkg::AddrW-1:0] buf_size;
  logic [rjfr_pkg::HdrW-1:0]  hdr_len;
  logic [rjfr_pkg::SlotW:0]   held_slot;
  logic [rjfr_pkg::AddrW-1:0] next_off;
  logic                       frame_bad;
  logic [rjfr_pkg::SeqW-1:0]  frame_seq;

  // Idling knobs, set per phase by the sequencer.
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned hold_req      = 0;
  int unsigned hold_left     = 0;

  logic        req_took = 1'b0;
  int unsigned errors = 0;
  int unsigned gen_count = 0;
  int unsigned req_count = 0;
  int unsigned result_count = 0;
  int unsigned frames_closed = 0;
  int unsigned input_stalls = 0;
  int unsigned cycle_count = 0;
  int unsigned status_seen[6];

  // Predict the verdict for one accepted request and advance the tracker.
  function automatic verdict_t judge_packet(rjfr_pkg::req_t p);
    verdict_t                  v;
    logic [rjfr_pkg::LenW-1:0] plen;
    logic [63:0]               reach;
    v        = '0;
    v.status = rjfr_pkg::ST_DISCARD;
    if (p.packet_length < rjfr_pkg::MinPacketBytes) begin
      // Short packets leave the tracker alone, marker or not.
      v.status = rjfr_pkg::ST_SHORT;
      v.slot   = (held_slot < NoSlot) ? held_slot[rjfr_pkg::SlotW-1:0] : '0;
      return v;
    end
    plen = p.packet_length - rjfr_pkg::MinPacketBytes;
    if (p.fragment_offset == '0) begin
      // Lowest free slot among those that have a mask bit.
      held_slot = NoSlot;
      for (int unsigned k = 0; k < rjfr_pkg::NumSlots && k < rjfr_pkg::MaskW; k++)
        if (p.free_slots[k] && held_slot == NoSlot)
          held_slot = (rjfr_pkg::SlotW+1)'(k);
      frame_bad = (held_slot == NoSlot);
      if (frame_bad) v.status = rjfr_pkg::ST_NOSLOT;
      else v.start = 1'b1;
      next_off = '0;
    end
    if (!frame_bad && held_slot < NoSlot) begin
      if (rjfr_pkg::AddrW'(p.fragment_offset) != next_off) begin
        frame_bad = 1'b1;
        v.status  = rjfr_pkg::ST_GAP;
      end else begin
        // Two bytes stay reserved for the end marker.
        reach = 64'(hdr_len) + 64'(p.fragment_offset) + 64'(plen)
              + 64'(rjfr_pkg::EoiBytes);
        if (reach <= 64'(buf_size)) begin
          v.status = rjfr_pkg::ST_WRITTEN;
          v.waddr  = rjfr_pkg::AddrW'(hdr_len) + rjfr_pkg::AddrW'(p.fragment_offset);
          v.wlen   = plen;
          next_off = rjfr_pkg::AddrW'(p.fragment_offset) + rjfr_pkg::AddrW'(plen);
        end else begin
          frame_bad = 1'b1;
          v.status  = rjfr_pkg::ST_OVERFLOW;
        end
      end
    end
    v.slot = (held_slot < NoSlot) ? held_slot[rjfr_pkg::SlotW-1:0] : '0;
    if (p.marker) begin
      if (!frame_bad && held_slot < NoSlot) begin
        v.done    = 1'b1;
        v.fsize   = rjfr_pkg::AddrW'(hdr_len) + next_off + rjfr_pkg::EoiBytes;
        v.fseq    = frame_seq;
        frame_seq = frame_seq + 1'b1;
      end
      held_slot = NoSlot;
      next_off  = '0;
      frame_bad = 1'b1;
    end
    return v;
  endfunction

  task automatic cmp_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (got_v !== want_v) begin
      errors++;
      $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
    end
  endtask

  task automatic put(int unsigned len, bit mark, int unsigned off, int unsigned mask);
    rjfr_pkg::req_t p;
    p.packet_length   = rjfr_pkg::LenW'(len);
    p.marker          = mark;
    p.fragment_offset = rjfr_pkg::OffW'(off);
    p.free_slots      = rjfr_pkg::MaskW'(mask);
    header_q.push_back(p);
    if (len >= 20) gen_count++;
  endtask

  // One frame of contiguous fragments, now and then broken: a gap, a stray
  // short packet, or a missing marker.
  task automatic push_frame(int unsigned nfrag);
    int unsigned at;
    int unsigned plen;
    int unsigned r;
    int unsigned off_use;
    bit          mark;
    at = 0;
    for (int unsigned i = 0; i < nfrag; i++) begin
      r = $urandom_range(99);
      case ($urandom_range(9))
        0:       plen = $urandom_range(0, 65515);
        1, 2:    plen = $urandom_range(0, 4000);
        default: plen = $urandom_range(0, 400);
      endcase
      off_use = at;
      mark    = (i == nfrag - 1);
      if (r < 3) begin
        off_use = at + $urandom_range(1, 300);
      end else if (r < 6) begin
        put($urandom_range(0, 19), $urandom_range(0, 1), $urandom(), $urandom_range(0, 15));
      end else if (r < 8 && mark) begin
        mark = 1'b0;
      end
      put(plen + 20, mark, off_use,
          (i != 0) ? $urandom_range(0, 15) :
          ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 15));
      at = at + plen;
    end
  endtask

  // Mostly well-formed frames, the rest random headers.
  task automatic push_mix(int unsigned n);
    int unsigned target;
    target = gen_count + n;
    while (gen_count < target) begin
      if ($urandom_range(99) < 80) begin
        push_frame($urandom_range(1, 6));
      end else begin
        put($urandom_range(0, 65535), $urandom_range(0, 1),
            ($urandom_range(3) == 0) ? 0 : $urandom(), $urandom_range(0, 15));
      end
    end
  endtask

  // Waits for the block to go idle: nothing queued, offered or outstanding.
  task automatic drain();
    while (header_q.size() != 0 || req_if.valid || verdict_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(rjfr_pkg::cfg_idx_e idx, logic [rjfr_pkg::CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == rjfr_pkg::CFG_BUFFER_SIZE) buf_size = val;
    else hdr_len = val[rjfr_pkg::HdrW-1:0];
  endtask

  // Request driver: a new header goes out at the falling edge once the last
  // one was taken, unless this cycle is an idle one.
  always @(negedge clk_i) begin
    rjfr_pkg::req_t nxt;
    if (rst_ni && (!req_if.valid || req_took)) begin
      if (header_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = header_q.pop_front();
        req_if.valid           <= 1'b1;
        req_if.packet_length   <= nxt.packet_length;
        req_if.marker          <= nxt.marker;
        req_if.fragment_offset <= nxt.fragment_offset;
        req_if.free_slots      <= nxt.free_slots;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Result ready: a long hold-off when asked, random stalls otherwise.
  always @(negedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Monitor: checks each result against the oldest verdict, then predicts
  // the verdict of any request taken at this edge.
  always @(posedge clk_i) begin
    verdict_t       want;
    rjfr_pkg::req_t seen;
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        result_count++;
        if (verdict_q.size() == 0) begin
          errors++;
          $error("result arrived with no request outstanding");
        end else begin
          want = verdict_q.pop_front();
          cmp_field("status", 32'(want.status), 32'(res_if.status));
          cmp_field("slot", 32'(want.slot), 32'(res_if.slot));
          cmp_field("start_frame", 32'(want.start), 32'(res_if.start_frame));
          cmp_field("write_address", 32'(want.waddr), 32'(res_if.write_address));
          cmp_field("write_length", 32'(want.wlen), 32'(res_if.write_length));
          cmp_field("frame_done", 32'(want.done), 32'(res_if.frame_done));
          cmp_field("frame_size", 32'(want.fsize), 32'(res_if.frame_size));
          cmp_field("frame_sequence", want.fseq, res_if.frame_sequence);
        end
      end
      if (req_if.valid && !req_if.ready) input_stalls++;
      if (req_if.valid && req_if.ready) begin
        seen.packet_length   = req_if.packet_length;
        seen.marker          = req_if.marker;
        seen.fragment_offset = req_if.fragment_offset;
        seen.free_slots      = req_if.free_slots;
        want = judge_packet(seen);
        status_seen[int'(want.status)]++;
        if (want.done) frames_closed++;
        verdict_q.push_back(want);
        req_count++;
      end
      req_took <= req_if.valid && req_if.ready;
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles, %0d verdicts outstanding", cycle_count,
               verdict_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Sequencer: reset, then phases separated by idle register writes.
  initial begin
    rst_ni                 = 1'b0;
    req_if.valid           = 1'b0;
    req_if.packet_length   = '0;
    req_if.marker          = 1'b0;
    req_if.fragment_offset = '0;
    req_if.free_slots      = '0;
    res_if.ready           = 1'b0;
    cfg_we_i               = 1'b0;
    cfg_idx_i              = rjfr_pkg::CFG_BUFFER_SIZE;
    cfg_data_i             = '0;
    buf_size  = rjfr_pkg::BufSizeReset;
    hdr_len   = rjfr_pkg::HdrLenReset;
    held_slot = NoSlot;
    next_off  = '0;
    frame_bad = 1'b1;
    frame_seq = rjfr_pkg::SeqReset;
    foreach (status_seen[i]) status_seen[i] = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed, reset register values, no idling.
    put(0, 1, 0, 4'hF);                 // short with marker: state untouched
    put(19, 0, 0, 4'hF);                // longest short packet
    put(20, 0, 5, 4'hF);                // no frame open: discarded
    put(120, 0, 0, 4'h0);               // frame start, mask empty
    put(70, 0, 100, 4'hF);              // rest of the dropped frame
    put(20, 0, 0, 4'h8);                // claim top slot, empty payload
    put(120, 0, 0, 4'h6);               // restart claims slot 1
    put(60, 0, 100, 4'h0);
    put(10, 1, 0, 4'h0);                // short while a slot is held
    put(65535, 1, 140, 4'h0);           // largest payload closes the frame
    put(1020, 1, 0, 4'hF);              // single-packet frame
    put(220, 0, 0, 4'h1);
    put(70, 0, 300, 4'h1);              // gap
    put(70, 1, 200, 4'h1);              // tail of a corrupt frame
    put(65535, 0, 0, 4'h2);
    put(65535, 0, 65515, 4'h2);
    put(65535, 0, 131030, 4'h2);
    put(65535, 0, 196545, 4'h2);        // runs past the buffer
    put(40, 1, 262060, 4'h2);
    put(20, 1, 24'hFFFFFF, 4'hF);       // top offset, nothing held
    put(500, 1, 0, 4'h0);               // no slot, marker set
    put(120, 0, 0, 4'h8);               // left open across the header change
    drain();

    // A 1024-byte buffer, zero header; sender idles.
    write_reg(rjfr_pkg::CFG_BUFFER_SIZE, 25'd1024);
    write_reg(rjfr_pkg::CFG_HEADER_LENGTH, 25'd0);
    send_idle_pct = 46;
    put(70, 1, 100, 4'h0);              // finishes the open frame, new header
    push_mix(220);
    drain();

    // A 16777216-byte buffer and the largest header; receiver stalls.
    write_reg(rjfr_pkg::CFG_BUFFER_SIZE, 25'd16777216);
    write_reg(rjfr_pkg::CFG_HEADER_LENGTH, 25'd1023);
    send_idle_pct = 0;
    stall_pct     = 46;
    push_mix(220);
    drain();

    // Random settings; both sides idle now and then.
    write_reg(rjfr_pkg::CFG_BUFFER_SIZE,
              rjfr_pkg::CfgDataW'($urandom_range(1024, 65536)));
    write_reg(rjfr_pkg::CFG_HEADER_LENGTH,
              rjfr_pkg::CfgDataW'($urandom_range(0, 1023)));
    send_idle_pct = 12;
    stall_pct     = 12;
    push_mix(220);
    drain();

    // Back to the reset values; the receiver holds off while the sender
    // keeps offering, so the pipeline fills and ready drops.
    write_reg(rjfr_pkg::CFG_BUFFER_SIZE, rjfr_pkg::BufSizeReset);
    write_reg(rjfr_pkg::CFG_HEADER_LENGTH, rjfr_pkg::CfgDataW'(rjfr_pkg::HdrLenReset));
    send_idle_pct = 0;
    stall_pct     = 0;
    push_mix(200);
    hold_req = 80;
    drain();

    // Buffer too small for anything: every fragment that reaches the fit check overflows.
    write_reg(rjfr_pkg::CFG_BUFFER_SIZE, 25'd1);
    write_reg(rjfr_pkg::CFG_HEADER_LENGTH, 25'd0);
    send_idle_pct = 46;
    stall_pct     = 46;
    put(20, 1, 0, 4'hF);
    push_mix(40);
    drain();

    $display("Covered %0d packets, %0d results, %0d frames closed, %0d input stalls, %0d cycles",
             req_count, result_count, frames_closed, input_stalls, cycle_count);
    $display("Status mix short/discard/noslot/gap/overflow/written: %0d/%0d/%0d/%0d/%0d/%0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5]);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
